// ===== design/assert_macros.svh =====
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	`ASSERT_PROP(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ===== design/npcq_pkg.sv =====
// types and constants for the nearest palette color quantizer
`timescale 1ns / 1ps

package npcq_pkg;

	localparam int PalCount = 8;
	localparam int IdxW     = 3;
	localparam int ChW      = 8;
	localparam int ColorW   = 3 * ChW;
	localparam int DistW    = 18;
	localparam int CfgAddrW = 4;
	localparam int InDataW  = 24;
	localparam int OutDataW = 32;

	// larger than any squared distance, so the first cell always takes over
	localparam logic [DistW-1:0] DistInit = '1;
	// largest real squared distance, 3 * 255 * 255
	localparam logic [DistW-1:0] DistMax  = DistW'(3 * 255 * 255);

	// palette after reset, packed ch2 ch1 ch0
	localparam logic [ColorW-1:0] PalReset [PalCount] = '{
		24'h000000, 24'hFFFFFF, 24'h80FFFF, 24'hFFFF80,
		24'hFF80FF, 24'h8080FF, 24'h80FF80, 24'hFF8080
	};

	// palette register write request for one cell
	typedef struct packed {
		logic              en;
		logic [ColorW-1:0] data;
	} cfg_wr_t;

	// what moves from cell to cell: the pixel and the best match so far
	typedef struct packed {
		logic [ColorW-1:0] pixel;
		logic [DistW-1:0]  best_dist;
		logic [IdxW-1:0]   best_idx;
		logic [ColorW-1:0] best_color;
	} item_t;

endpackage

// ===== design/npcq_cell.sv =====
// one cell of the chain: holds one palette entry and updates the best match
`timescale 1ns / 1ps

module npcq_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  npcq_pkg::cfg_wr_t                cfg,
	input  logic [npcq_pkg::ColorW-1:0]      reset_color,
	input  logic [npcq_pkg::IdxW-1:0]        cell_idx,
	input  logic                             up_valid,
	output logic                             up_ready,
	input  npcq_pkg::item_t                  up_item,
	output logic                             down_valid,
	input  logic                             down_ready,
	output npcq_pkg::item_t                  down_item
);

	// palette entry stored relative to its reset value so reset clears to zero
	logic [npcq_pkg::ColorW-1:0] color_q;
	logic [npcq_pkg::ColorW-1:0] color;
	logic                        valid_q;
	npcq_pkg::item_t             item_q;
	npcq_pkg::item_t             item_next;
	logic [npcq_pkg::ChW-1:0]    diff [3];
	logic [2*npcq_pkg::ChW-1:0]  sq [3];
	logic [npcq_pkg::DistW-1:0]  sq_dist;

	assign color = color_q ^ reset_color;

	// palette register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= '0;
		end else if (cfg.en) begin
			color_q <= cfg.data ^ reset_color;
		end
	end

	// squared distance from the pixel to this entry
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (up_item.pixel[c*npcq_pkg::ChW +: npcq_pkg::ChW] >
			    color[c*npcq_pkg::ChW +: npcq_pkg::ChW]) begin
				diff[c] = up_item.pixel[c*npcq_pkg::ChW +: npcq_pkg::ChW] -
				          color[c*npcq_pkg::ChW +: npcq_pkg::ChW];
			end else begin
				diff[c] = color[c*npcq_pkg::ChW +: npcq_pkg::ChW] -
				          up_item.pixel[c*npcq_pkg::ChW +: npcq_pkg::ChW];
			end
			sq[c] = (2*npcq_pkg::ChW)'(diff[c]) * (2*npcq_pkg::ChW)'(diff[c]);
		end
		sq_dist = npcq_pkg::DistW'(sq[0]) + npcq_pkg::DistW'(sq[1]) +
		          npcq_pkg::DistW'(sq[2]);
	end

	// strict compare keeps the lower index on a tie
	always_comb begin
		item_next = up_item;
		if (sq_dist < up_item.best_dist) begin
			item_next.best_dist  = sq_dist;
			item_next.best_idx   = cell_idx;
			item_next.best_color = color;
		end
	end

	// a cell takes a new request when empty or when its own one moves on
	assign up_ready = !valid_q || down_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			item_q <= item_next;
		end
	end

	assign down_valid = valid_q;
	assign down_item  = item_q;

endmodule

// ===== design/nearest_palette_color_quantizer.sv =====
// top level: chain of eight palette cells with stream ports and register writes
//
// Maps each 3-channel 8-bit pixel to the nearest of eight palette colors.
// Input stream s_*: one pixel per request, accepted when s_tvalid and s_tready
// are both high. Output stream m_*: the chosen color and its index.
// Palette registers are written through cfg_we / cfg_addr / cfg_wdata; index 0
// to 7 selects the entry, higher indexes are ignored. Write only while idle.
// Each of the eight cells holds one entry and is one register stage; a pixel
// walks the chain carrying the best match found so far.
// Throughput: one pixel per clock while m_tready stays high; the cell stages set this figure.
// Reset restores the default palette and empties the chain.
// When the receiver stalls, the result holds in the last cell and the chain
// keeps taking pixels until every cell is full, then s_tready drops.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module nearest_palette_color_quantizer (
	input  logic                             clk,
	input  logic                             arst_n,
	// palette writes
	input  logic                             cfg_we,
	input  logic [npcq_pkg::CfgAddrW-1:0]    cfg_addr,
	input  logic [npcq_pkg::ColorW-1:0]      cfg_wdata,
	// pixel requests
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [npcq_pkg::InDataW-1:0]     s_tdata,  // pixel_ch0, pixel_ch1, pixel_ch2
	// results
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [npcq_pkg::OutDataW-1:0]    m_tdata   // out_ch0, out_ch1, out_ch2, palette_index, pad
);

	logic              valid_c [npcq_pkg::PalCount+1];
	logic              ready_c [npcq_pkg::PalCount+1];
	npcq_pkg::item_t   item_c  [npcq_pkg::PalCount+1];
	npcq_pkg::cfg_wr_t cfg_c   [npcq_pkg::PalCount];

	// head of the chain: pixel with no match yet
	assign valid_c[0]            = s_tvalid;
	assign s_tready              = ready_c[0];
	assign item_c[0].pixel       = s_tdata[npcq_pkg::ColorW-1:0];
	assign item_c[0].best_dist   = npcq_pkg::DistInit;
	assign item_c[0].best_idx    = '0;
	assign item_c[0].best_color  = '0;

	// one cell per palette entry
	for (genvar i = 0; i < npcq_pkg::PalCount; i++) begin : g_cell
		assign cfg_c[i].en   = cfg_we && (cfg_addr == npcq_pkg::CfgAddrW'(i));
		assign cfg_c[i].data = cfg_wdata;

		npcq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cfg         (cfg_c[i]),
			.reset_color (npcq_pkg::PalReset[i]),
			.cell_idx    (npcq_pkg::IdxW'(i)),
			.up_valid    (valid_c[i]),
			.up_ready    (ready_c[i]),
			.up_item     (item_c[i]),
			.down_valid  (valid_c[i+1]),
			.down_ready  (ready_c[i+1]),
			.down_item   (item_c[i+1])
		);
	end

	// tail of the chain drives the result
	assign m_tvalid = valid_c[npcq_pkg::PalCount];
	assign ready_c[npcq_pkg::PalCount] = m_tready;
	assign m_tdata  = {
		(npcq_pkg::OutDataW - npcq_pkg::ColorW - npcq_pkg::IdxW)'(0),
		item_c[npcq_pkg::PalCount].best_idx,
		item_c[npcq_pkg::PalCount].best_color
	};

	// an empty or draining tail means the head takes requests
	`ASSERT_IMPL(a_head_ready, clk, arst_n, !m_tvalid || m_tready, s_tready, "chain blocked while tail free")
	// a finished result always carries a real distance
	`ASSERT_IMPL(a_dist_real, clk, arst_n, m_tvalid, item_c[npcq_pkg::PalCount].best_dist <= npcq_pkg::DistMax, "result without a match")
	// the first cell always takes the match
	`ASSERT_IMPL(a_first_cell, clk, arst_n, valid_c[1], item_c[1].best_idx == '0, "first cell did not take match")

endmodule

// ===== sim/tb_nearest_palette_color_quantizer.sv =====
// self-checking testbench for the nearest palette color quantizer
`timescale 1ns / 1ps

module tb_nearest_palette_color_quantizer;
	import npcq_pkg::*;

	localparam int ClkPeriod = 20;
	localparam int CycleLimit = 300000;
	localparam int DrainCycles = 20;
	localparam int PixelsPerPhase = 150;
	localparam int LongHoldAt = 300;
	localparam int LongHoldLen = 150;

	// register indexes
	localparam logic [CfgAddrW-1:0] RegPal0 = '0;
	localparam logic [CfgAddrW-1:0] RegFirstUnused = CfgAddrW'(PalCount);
	localparam logic [CfgAddrW-1:0] RegLastUnused = '1;

	// pixel and palette entry, ch0 in the low byte
	typedef struct packed {
		logic [ChW-1:0] ch2;
		logic [ChW-1:0] ch1;
		logic [ChW-1:0] ch0;
	} pixel_t;

	// result word as it leaves m_tdata
	typedef struct packed {
		logic [OutDataW-ColorW-IdxW-1:0] pad;
		logic [IdxW-1:0]                 idx;
		logic [ChW-1:0]                  ch2;
		logic [ChW-1:0]                  ch1;
		logic [ChW-1:0]                  ch0;
	} match_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CfgAddrW-1:0] cfg_addr = '0;
	logic [ColorW-1:0]   cfg_wdata = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OutDataW-1:0] m_tdata;

	// palette as the block should hold it
	pixel_t pal_copy [PalCount];

	pixel_t pending_pixels [$];
	match_t awaited_matches [$];

	int  src_idle_pct = 0;
	int  snk_idle_pct = 0;
	int  err_cnt = 0;
	int  matches_seen = 0;
	int  cycle_cnt = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	bit  pixel_taken = 1'b0;

	nearest_palette_color_quantizer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #(ClkPeriod / 2) clk = ~clk;
	end

	// nearest palette entry by squared distance, lowest index on ties
	function automatic match_t nearest_entry(pixel_t px);
		pixel_t          c;
		logic [ChW-1:0]  d0, d1, d2;
		logic [DistW-1:0] sq_dist, best_dist;
		logic [IdxW-1:0] best;
		match_t          m;
		best = '0;
		best_dist = '0;
		for (int i = 0; i < PalCount; i++) begin
			c = pal_copy[i];
			d0 = (px.ch0 > c.ch0) ? px.ch0 - c.ch0 : c.ch0 - px.ch0;
			d1 = (px.ch1 > c.ch1) ? px.ch1 - c.ch1 : c.ch1 - px.ch1;
			d2 = (px.ch2 > c.ch2) ? px.ch2 - c.ch2 : c.ch2 - px.ch2;
			sq_dist = DistW'(d0) * DistW'(d0) + DistW'(d1) * DistW'(d1)
				+ DistW'(d2) * DistW'(d2);
			if (i == 0 || sq_dist < best_dist) begin
				best = IdxW'(i);
				best_dist = sq_dist;
			end
		end
		c = pal_copy[best];
		m.pad = '0;
		m.idx = best;
		m.ch2 = c.ch2;
		m.ch1 = c.ch1;
		m.ch0 = c.ch0;
		return m;
	endfunction

	// random pixel: uniform half the time, else near an entry, extreme, or between two entries
	function automatic pixel_t random_pixel();
		pixel_t px, a, b;
		int     k, v;
		k = $urandom_range(9);
		a = pal_copy[$urandom_range(PalCount - 1)];
		b = pal_copy[$urandom_range(PalCount - 1)];
		px = pixel_t'(ColorW'($urandom));
		for (int j = 0; j < 3; j++) begin
			if (k >= 5 && k <= 7) begin
				v = int'(a[ChW*j +: ChW]) + int'($urandom_range(6)) - 3;
				v = (v < 0) ? 0 : (v > 255) ? 255 : v;
				px[ChW*j +: ChW] = ChW'(v);
			end else if (k == 8) begin
				px[ChW*j +: ChW] = $urandom_range(1) ? 8'hFF : 8'h00;
			end else if (k == 9) begin
				px[ChW*j +: ChW] = ChW'((int'(a[ChW*j +: ChW]) + int'(b[ChW*j +: ChW])) / 2);
			end
		end
		return px;
	endfunction

	// one palette register write, the local copy follows it
	task automatic write_reg(logic [CfgAddrW-1:0] addr, logic [ColorW-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (addr < RegFirstUnused)
			pal_copy[addr[IdxW-1:0]] = pixel_t'(val);
	endtask

	// new palette; mode 1 keeps channels at 0 or 255, mode 2 makes all entries equal
	task automatic load_random_palette(int mode);
		logic [ColorW-1:0] val;
		logic [ColorW-1:0] same;
		same = ColorW'($urandom);
		for (int i = 0; i < PalCount; i++) begin
			val = ColorW'($urandom);
			if (mode == 1) begin
				for (int j = 0; j < 3; j++)
					val[ChW*j +: ChW] = $urandom_range(1) ? 8'hFF : 8'h00;
			end else if (mode == 2) begin
				val = same;
			end else if (i > 0 && $urandom_range(4) == 0) begin
				val = pal_copy[$urandom_range(i - 1)];
			end
			write_reg(RegPal0 + CfgAddrW'(i), val);
		end
	endtask

	// wait until every request is taken and every result has come back
	task automatic wait_idle();
		while (pending_pixels.size() != 0 || s_tvalid || awaited_matches.size() != 0)
			@(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	task automatic report_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			err_cnt++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
		end
	endtask

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || pixel_taken) begin
			if (pending_pixels.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata <= pending_pixels[0];
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result receiver, with one long hold-off to fill the chain
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (!hold_done && matches_seen >= LongHoldAt) begin
			hold_done <= 1'b1;
			hold_left <= LongHoldLen;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// monitor: predict on accepted requests, check accepted results
	always @(posedge clk) begin
		match_t got, want;
		pixel_taken = 1'b0;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				pixel_taken = 1'b1;
				awaited_matches.push_back(nearest_entry(pixel_t'(s_tdata)));
				void'(pending_pixels.pop_front());
			end
			if (m_tvalid && m_tready) begin
				got = match_t'(m_tdata);
				matches_seen++;
				if (awaited_matches.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
				end else begin
					want = awaited_matches.pop_front();
					report_field("out_ch0", want.ch0, got.ch0);
					report_field("out_ch1", want.ch1, got.ch1);
					report_field("out_ch2", want.ch2, got.ch2);
					report_field("palette_index", want.idx, got.idx);
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CycleLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// stimulus
	initial begin
		for (int i = 0; i < PalCount; i++)
			pal_copy[i] = pixel_t'(PalReset[i]);
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// default palette: each entry exactly, channel extremes, grays
		for (int i = 0; i < PalCount; i++)
			pending_pixels.push_back(pixel_t'(PalReset[i]));
		pending_pixels.push_back(pixel_t'(24'hFF0000));
		pending_pixels.push_back(pixel_t'(24'h00FF00));
		pending_pixels.push_back(pixel_t'(24'h0000FF));
		pending_pixels.push_back(pixel_t'(24'h7F7F7F));
		pending_pixels.push_back(pixel_t'(24'h808080));
		pending_pixels.push_back(pixel_t'(24'h404040));
		pending_pixels.push_back(pixel_t'(24'hC0C0C0));
		wait_idle();

		// exact tie between entries 0 and 1, equal entries 2 to 7
		write_reg(RegPal0, 24'h000000);
		write_reg(RegPal0 + CfgAddrW'(1), 24'h000002);
		for (int i = 2; i < PalCount; i++)
			write_reg(RegPal0 + CfgAddrW'(i), 24'hFFFFFF);
		pending_pixels.push_back(pixel_t'(24'h000001));
		pending_pixels.push_back(pixel_t'(24'h000002));
		pending_pixels.push_back(pixel_t'(24'hFFFFFF));
		pending_pixels.push_back(pixel_t'(24'h7F7F7F));
		wait_idle();

		// writes past the last entry must leave the palette alone
		write_reg(RegFirstUnused, 24'h123456);
		write_reg(RegLastUnused, 24'h123456);
		pending_pixels.push_back(pixel_t'(24'h123456));
		wait_idle();

		// random palettes (the default palette in the last phase) and pixels under three idling patterns
		for (int ph = 0; ph < 9; ph++) begin
			if (ph < 3) begin
				src_idle_pct = 11;
				snk_idle_pct = 68;
			end else if (ph < 6) begin
				src_idle_pct = 68;
				snk_idle_pct = 11;
			end else begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			if (ph == 8) begin
				for (int i = 0; i < PalCount; i++)
					write_reg(RegPal0 + CfgAddrW'(i), PalReset[i]);
			end else begin
				load_random_palette((ph == 2) ? 1 : (ph == 5) ? 2 : 0);
			end
			for (int n = 0; n < PixelsPerPhase; n++)
				pending_pixels.push_back(random_pixel());
			wait_idle();
		end

		if (err_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
